[hw/rtl/amf_pkg.sv]
// Shared types, constants and helper functions for the adaptive median filter.
`timescale 1ns / 1ps
package amf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 3;
   localparam int WIN_ROWS    = 2 * MAX_RADIUS + 1;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   // The line store keeps the window rows plus the row being filled, rounded
   // up to a power of two so that a row maps to its slot by its low bits.
   localparam int SLOT_BITS   = $clog2(WIN_ROWS + 1);
   localparam int SLOT_ROWS   = 2 ** SLOT_BITS;
   localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
   localparam int RAM_DEPTH   = SLOT_ROWS * MAX_WIDTH;
   localparam int STORE_DEPTH = WIN_ROWS * MAX_WIDTH;
   localparam int CNT_BITS    = $clog2(WIN_ROWS * WIN_ROWS + 1);

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MIN_RADIUS   = 2'd2;
   localparam logic [1:0] REG_MAX_RADIUS   = 2'd3;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Control that travels with each sample read from the line store.
   typedef struct packed {
      logic clear_cnt;
      logic clear_ext;
      logic valid;
      logic centre;
      logic first;
   } rank_ctrl_type;

   // Reflect with edge repeat, then clamp to the edge for tiny sizes.
   function automatic logic [12:0] mirror(input logic signed [13:0] i,
                                          input logic [12:0] n);
      logic signed [14:0] v;
      logic signed [14:0] nn;
      begin
         v  = {i[13], i};
         nn = {2'b00, n};
         if (v < 15'sd0) v = -v - 15'sd1;
         if (v >= nn) v = 15'sd2 * nn - 15'sd1 - v;
         if (v < 15'sd0) v = 15'sd0;
         if (v >= nn) v = nn - 15'sd1;
         return v[12:0];
      end
   endfunction

   // Median rank (count of window pixels divided by two) per radius.
   function automatic logic [CNT_BITS-1:0] median_rank(input logic [2:0] r);
      logic [CNT_BITS-1:0] side;
      begin
         side = CNT_BITS'({r, 1'b1});
         return CNT_BITS'((side * side) >> 1);
      end
   endfunction

endpackage

[hw/rtl/adaptive_median_filter_core.sv]
// Adaptive median filter core: line store, window sequencer and result port.
`timescale 1ns / 1ps
// Pixels enter in raster order on the req_ channel (tuser = 1 marks a drain
// beat without a pixel) and are written into a line store of eight row slots
// of up to 1024 pixels: the seven window rows plus the row being filled.
// Each result trails the input by three rows plus three columns and appears
// on the rsp_ channel with tlast set on the last pixel of the frame. The block
// works on one beat at a time. For each window radius r tried, the median is
// found bit by bit in eight passes over the window, and every pass reads the
// window one pixel per cycle through the single read port of the line store.
// The line store needs no clearing after reset. Registers are written over
// the csr_ port; the user must write them only while the block is idle, as
// the block itself does not enforce it.
module adaptive_median_filter_core
   import amf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel_value[7:0]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // filtered_pixel[7:0], out_row[19:8], out_col[29:20]
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_DECIDE, ST_PASS, ST_PASS_END, ST_BIT, ST_EVAL, ST_FINISH
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [10:0] width_ff;
   logic [11:0] height_ff;
   logic [1:0]  rmin_ff;
   logic [1:0]  rmax_ff;

   // Frame position counters; the low bits of a row pick its line store slot.
   logic [11:0]          in_row_ff;
   logic [9:0]           in_col_ff;
   logic [11:0]          er_ff;
   logic [9:0]           ec_ff;

   // Per-beat decision.
   logic        wrote_ff;
   logic [22:0] recv_ff;
   logic [22:0] emitted_ff;

   // Window sequencer.
   logic [2:0]        r_ff;
   logic signed [3:0] dy_ff;
   logic signed [3:0] dx_ff;
   logic [2:0]        bit_ff;
   logic [7:0]        med_ff;
   logic              smp_v_ff;
   logic              smp_c_ff;
   logic              smp_f_ff;
   logic [7:0]        result_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [7:0]  rsp_pix_ff;
   logic [11:0] rsp_row_ff;
   logic [9:0]  rsp_col_ff;
   logic        rsp_last_ff;

   logic [10:0] w_eff;
   logic [11:0] h_eff;
   logic        cfg_wr;

   assign w_eff = (width_ff == 11'd0) ? 11'd1 :
                  (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == 12'd0) ? 12'd1 : height_ff;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_FRAME_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {20'd0, height_ff};
         REG_MIN_RADIUS:   csr_prdata = {30'd0, rmin_ff};
         REG_MAX_RADIUS:   csr_prdata = {30'd0, rmax_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Input side: a pixel is written at its row slot as soon as it is taken.
   logic        accept;
   logic        do_write;
   logic [10:0] in_c;
   logic [10:0] in_c_next;

   assign accept    = req_tvalid && req_tready;
   assign do_write  = accept && (req_tuser == CMD_PIXEL) && (in_row_ff < h_eff);
   assign in_c      = ({1'b0, in_col_ff} >= w_eff) ? (w_eff - 11'd1) : {1'b0, in_col_ff};
   assign in_c_next = in_c + 11'd1;

   // Window address: reflected row and column, row mapped to its slot.
   logic signed [13:0]   row_i;
   logic signed [13:0]   col_i;
   logic [11:0]          yy;
   logic [9:0]           xx;
   logic [12:0]          yy_full;
   logic [12:0]          xx_full;

   assign row_i    = $signed({2'b00, er_ff}) + $signed({{10{dy_ff[3]}}, dy_ff});
   assign col_i    = $signed({4'b0000, ec_ff}) + $signed({{10{dx_ff[3]}}, dx_ff});
   assign yy_full  = mirror(row_i, {1'b0, h_eff});
   assign xx_full  = mirror(col_i, {2'b00, w_eff});
   assign yy       = yy_full[11:0];
   assign xx       = xx_full[9:0];

   logic [7:0] rd_data;

   amf_line_ram u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr ({in_row_ff[SLOT_BITS-1:0], in_c[COL_BITS-1:0]}),
      .wr_data (req_tdata),
      .rd_addr ({yy[SLOT_BITS-1:0], xx}),
      .rd_data (rd_data)
   );

   // Rank statistics over the samples coming back from the line store.
   rank_ctrl_type       rctrl;
   logic [7:0]          trial;
   logic [CNT_BITS-1:0] cnt;
   logic [7:0]          lo;
   logic [7:0]          hi;
   logic [7:0]          centre;
   logic                emit;
   logic [2:0]          r_next;
   logic                med_ok;

   // Candidate for the current bit: decided upper bits, this bit zero, lower bits one.
   assign trial  = med_ff | ((8'd1 << bit_ff) - 8'd1);
   assign emit   = (recv_ff > emitted_ff + (23'(w_eff) * 23'd3 + 23'd3)) ||
                   ((in_row_ff >= h_eff) && !wrote_ff);
   assign r_next = r_ff + 3'd1;
   assign med_ok = (med_ff > lo) && (med_ff < hi);

   always_comb begin
      rctrl.valid     = smp_v_ff;
      rctrl.centre    = smp_c_ff;
      rctrl.first     = smp_f_ff;
      rctrl.clear_cnt = 1'b0;
      rctrl.clear_ext = 1'b0;
      unique case (state_ff)
         ST_DECIDE: begin
            rctrl.clear_cnt = 1'b1;
            rctrl.clear_ext = 1'b1;
         end
         ST_BIT: rctrl.clear_cnt = 1'b1;
         ST_EVAL: begin
            rctrl.clear_cnt = 1'b1;
            rctrl.clear_ext = 1'b1;
         end
         default: ;
      endcase
   end

   amf_rank_unit u_rank (
      .clock  (clock),
      .ctrl   (rctrl),
      .sample (rd_data),
      .trial  (trial),
      .cnt    (cnt),
      .lo     (lo),
      .hi     (hi),
      .centre (centre)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

   logic signed [3:0] r_s;
   logic [10:0]       ec_next;
   logic [11:0]       er_next;

   assign r_s     = $signed({1'b0, r_ff});
   assign ec_next = {1'b0, ec_ff} + 11'd1;
   assign er_next = (ec_next >= w_eff) ? er_ff + 12'd1 : er_ff;

   always_ff @(posedge clock) begin
      smp_v_ff <= !reset && (state_ff == ST_PASS);
      smp_c_ff <= (dy_ff == 4'sd0) && (dx_ff == 4'sd0);
      smp_f_ff <= (bit_ff == 3'd7);
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 12'd480;
         rmin_ff      <= 2'd1;
         rmax_ff      <= 2'd3;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         er_ff        <= '0;
         ec_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[10:0];
               REG_FRAME_HEIGHT: height_ff <= csr_pwdata[11:0];
               REG_MIN_RADIUS:   rmin_ff   <= csr_pwdata[1:0];
               REG_MAX_RADIUS:   rmax_ff   <= csr_pwdata[1:0];
               default: ;
            endcase
         end
         // The finish state loads the result register itself.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wrote_ff <= do_write;
                  if (do_write) begin
                     if (in_c_next >= w_eff) begin
                        in_col_ff <= '0;
                        in_row_ff <= in_row_ff + 12'd1;
                     end else begin
                        in_col_ff <= in_c_next[9:0];
                     end
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               // Pixels received so far against the position to emit next.
               recv_ff <= (in_row_ff >= h_eff) ? 23'(w_eff) * 23'(h_eff) :
                          23'(in_row_ff) * 23'(w_eff) + 23'(in_col_ff);
               emitted_ff <= 23'(er_ff) * 23'(w_eff) + 23'(ec_ff);
               state_ff   <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (emit) begin
                  if ({1'b0, ec_ff} >= w_eff) ec_ff <= 10'(w_eff - 11'd1);
                  r_ff     <= {1'b0, rmin_ff};
                  dy_ff    <= -$signed({2'b00, rmin_ff});
                  dx_ff    <= -$signed({2'b00, rmin_ff});
                  bit_ff   <= 3'd7;
                  med_ff   <= 8'd0;
                  state_ff <= ST_PASS;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PASS: begin
               if (dx_ff == r_s) begin
                  dx_ff <= -r_s;
                  if (dy_ff == r_s) begin
                     dy_ff    <= -r_s;
                     state_ff <= ST_PASS_END;
                  end else begin
                     dy_ff <= dy_ff + 4'sd1;
                  end
               end else begin
                  dx_ff <= dx_ff + 4'sd1;
               end
            end
            ST_PASS_END: state_ff <= ST_BIT;
            ST_BIT: begin
               // More than rank pixels at or below the candidate: this bit is zero.
               if (cnt <= median_rank(r_ff)) med_ff[bit_ff] <= 1'b1;
               if (bit_ff == 3'd0) begin
                  state_ff <= ST_EVAL;
               end else begin
                  bit_ff   <= bit_ff - 3'd1;
                  state_ff <= ST_PASS;
               end
            end
            ST_EVAL: begin
               if (med_ok) begin
                  result_ff <= ((centre > lo) && (centre < hi)) ? centre : med_ff;
                  state_ff  <= ST_FINISH;
               end else if (r_next > {1'b0, rmax_ff}) begin
                  result_ff <= med_ff;
                  state_ff  <= ST_FINISH;
               end else begin
                  r_ff     <= r_next;
                  dy_ff    <= -$signed({1'b0, r_next});
                  dx_ff    <= -$signed({1'b0, r_next});
                  bit_ff   <= 3'd7;
                  med_ff   <= 8'd0;
                  state_ff <= ST_PASS;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pix_ff   <= result_ff;
                  rsp_row_ff   <= er_ff;
                  rsp_col_ff   <= ec_ff;
                  rsp_last_ff  <= (er_next >= h_eff);
                  if (er_next >= h_eff) begin
                     in_row_ff <= '0;
                     in_col_ff <= '0;
                     er_ff     <= '0;
                     ec_ff     <= '0;
                  end else if (ec_next >= w_eff) begin
                     ec_ff <= '0;
                     er_ff <= er_next;
                  end else begin
                     ec_ff <= ec_next[9:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/amf_line_ram.sv]
// Line store: single write port, single read port, registered read data.
`timescale 1ns / 1ps
module amf_line_ram
   import amf_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [RAM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/amf_rank_unit.sv]
// Window statistics: running minimum, maximum, centre and rank count.
`timescale 1ns / 1ps
module amf_rank_unit
   import amf_pkg::*;
(
   input  logic                clock,
   input  rank_ctrl_type       ctrl,
   input  logic [7:0]          sample,
   input  logic [7:0]          trial,
   output logic [CNT_BITS-1:0] cnt,
   output logic [7:0]          lo,
   output logic [7:0]          hi,
   output logic [7:0]          centre
);

   logic [CNT_BITS-1:0] cnt_ff;
   logic [7:0]          lo_ff;
   logic [7:0]          hi_ff;
   logic [7:0]          centre_ff;

   always_ff @(posedge clock) begin
      if (ctrl.clear_cnt) begin
         cnt_ff <= '0;
      end else if (ctrl.valid && sample <= trial) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (ctrl.clear_ext) begin
         lo_ff <= 8'hFF;
         hi_ff <= 8'h00;
      end else if (ctrl.valid && ctrl.first) begin
         if (sample < lo_ff) lo_ff <= sample;
         if (sample > hi_ff) hi_ff <= sample;
         if (ctrl.centre) centre_ff <= sample;
      end
   end

   assign cnt    = cnt_ff;
   assign lo     = lo_ff;
   assign hi     = hi_ff;
   assign centre = centre_ff;

endmodule
